// ===== sv/sida_pkg.sv =====
`default_nettype none

package sida_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_ID_WIDTH    = 16;

    // Fan-in of the first level of the free-identifier search tree.
    localparam int GROUP_SIZE = 8;

    // Operation codes on the input port.
    localparam logic [1:0] OPC_INSERT = 2'd0;
    localparam logic [1:0] OPC_REMOVE = 2'd1;

    // Classified operation carried from front to back.
    typedef enum logic [1:0] {
        K_INSERT,
        K_REMOVE,
        K_QUERY
    } t_kind;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2,
        ST_MISS = 2'd3
    } t_status;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_HIT,
        S_UPD,
        S_GAP1,
        S_GAP2,
        S_PUSH
    } t_state;

    // Update strobes from the sequencer to the cell array.
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== sv/sida_fifo.sv =====
`default_nettype none

module sida_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    // Two-entry queue; the head is always registered.
    logic [WIDTH-1:0] r_data [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_cnt == 2'd2);
    assign o_empty   = (r_cnt == 2'd0);
    assign o_data    = r_data[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_do_push) begin
                r_wr <= !r_wr;
            end
            if (w_do_pop) begin
                r_rd <= !r_rd;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_data[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sida_front.sv =====
`default_nettype none

module sida_front #(
    parameter int ID_WIDTH = sida_pkg::DEF_ID_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [1:0]          i_operation,
    input  logic [ID_WIDTH-1:0] i_ident,
    input  logic                i_pop,
    output logic                o_empty,
    output sida_pkg::t_kind     o_kind,
    output logic [ID_WIDTH-1:0] o_ident
);

    import sida_pkg::*;

    localparam int QW = $bits(t_kind) + ID_WIDTH;

    t_kind           w_kind;
    logic [QW-1:0]   w_head;

    // Unused opcodes behave as a query.
    always_comb begin
        case (i_operation)
            OPC_INSERT: w_kind = K_INSERT;
            OPC_REMOVE: w_kind = K_REMOVE;
            default:    w_kind = K_QUERY;
        endcase
    end

    sida_fifo #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  ({w_kind, i_ident}),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (w_head),
        .o_empty (o_empty)
    );

    assign o_kind  = t_kind'(w_head[QW-1:ID_WIDTH]);
    assign o_ident = w_head[ID_WIDTH-1:0];

endmodule

`default_nettype wire

// ===== sv/sida_cells.sv =====
`default_nettype none

module sida_cells #(
    parameter int TABLE_DEPTH = sida_pkg::DEF_TABLE_DEPTH,
    parameter int ID_WIDTH    = sida_pkg::DEF_ID_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [ID_WIDTH-1:0]                  i_ident,
    input  sida_pkg::t_cell_ctl                  i_ctl,
    output logic                                 o_hit,
    output logic                                 o_full,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]     o_count,
    output logic [ID_WIDTH-1:0]                  o_free_ident,
    output logic                                 o_no_free
);

    import sida_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int NGRP  = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int NPAD  = NGRP * GROUP_SIZE;

    logic [ID_WIDTH-1:0]    r_ids [TABLE_DEPTH];
    logic [ID_WIDTH-1:0]    n_ids [TABLE_DEPTH];
    logic [CNT_W-1:0]       r_count;
    logic [TABLE_DEPTH-1:0] w_valid;
    logic [TABLE_DEPTH-1:0] w_lt;
    logic [TABLE_DEPTH-1:0] w_eq;
    logic [TABLE_DEPTH-1:0] r_lt;
    logic [TABLE_DEPTH-1:0] r_eq;
    logic                   r_hit;
    logic [TABLE_DEPTH-1:0] w_cand;
    logic [NPAD-1:0]        w_cand_pad;
    logic [ID_WIDTH-1:0]    w_val_pad [NPAD];
    logic [NGRP-1:0]        n_grp_any;
    logic [ID_WIDTH-1:0]    n_grp_val [NGRP];
    logic [NGRP-1:0]        r_grp_any;
    logic [ID_WIDTH-1:0]    r_grp_val [NGRP];
    logic                   w_found;
    logic [ID_WIDTH-1:0]    w_sel;
    logic [ID_WIDTH-1:0]    r_free;
    logic                   r_no_free;

    // Per-cell compare against the broadcast identifier.
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_valid[i] = (CNT_W'(i) < r_count);
            w_lt[i]    = w_valid[i] && (r_ids[i] < i_ident);
            w_eq[i]    = w_valid[i] && (r_ids[i] == i_ident);
        end
    end

    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
        logic [ID_WIDTH-1:0] w_ins_val;
        logic [ID_WIDTH-1:0] w_del_val;

        // The first cell at or above the identifier takes it; cells above
        // it take their lower neighbor.
        if (gi == 0) begin : g_lo
            assign w_ins_val = i_ident;
        end else begin : g_mid
            assign w_ins_val = r_lt[gi-1] ? i_ident : r_ids[gi-1];
        end

        if (gi == TABLE_DEPTH - 1) begin : g_top
            assign w_del_val = r_ids[gi];
            assign w_cand[gi] = w_valid[gi];
        end else begin : g_inner
            assign w_del_val = r_ids[gi+1];
            // A cell ends a run when it is the last valid one or its
            // successor is not its value plus one.
            assign w_cand[gi] = w_valid[gi] && (!w_valid[gi+1] ||
                                (ID_WIDTH'(r_ids[gi] + 1'b1) != r_ids[gi+1]));
        end

        assign n_ids[gi] = (i_ctl.ins && !r_lt[gi]) ? w_ins_val :
                           (i_ctl.del && !r_lt[gi]) ? w_del_val : r_ids[gi];
    end

    for (genvar gp = 0; gp < NPAD; gp++) begin : g_pad
        if (gp < TABLE_DEPTH) begin : g_real
            assign w_cand_pad[gp] = w_cand[gp];
            assign w_val_pad[gp]  = r_ids[gp];
        end else begin : g_fill
            assign w_cand_pad[gp] = 1'b0;
            assign w_val_pad[gp]  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ids <= n_ids;
        r_lt  <= w_lt;
        r_eq  <= w_eq;
        r_hit <= |r_eq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.ins) begin
            r_count <= r_count + 1'b1;
        end else if (i_ctl.del) begin
            r_count <= r_count - 1'b1;
        end
    end

    // First level of the search: lowest run end within each group.
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp_any[g] = 1'b0;
            n_grp_val[g] = '0;
            for (int k = GROUP_SIZE - 1; k >= 0; k--) begin
                if (w_cand_pad[g*GROUP_SIZE+k]) begin
                    n_grp_any[g] = 1'b1;
                    n_grp_val[g] = w_val_pad[g*GROUP_SIZE+k];
                end
            end
        end
    end

    // Second level: lowest group that has a run end.
    always_comb begin
        w_found = 1'b0;
        w_sel   = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                w_found = 1'b1;
                w_sel   = r_grp_val[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp_any <= n_grp_any;
        r_grp_val <= n_grp_val;
        r_free    <= w_found ? ID_WIDTH'(w_sel + 1'b1) : ID_WIDTH'(1);
        r_no_free <= w_found && (w_sel == '1);
    end

    assign o_hit        = r_hit;
    assign o_full       = (r_count == CNT_W'(TABLE_DEPTH));
    assign o_count      = r_count;
    assign o_free_ident = r_free;
    assign o_no_free    = r_no_free;

endmodule

`default_nettype wire

// ===== sv/sida_back.sv =====
`default_nettype none

module sida_back #(
    parameter int TABLE_DEPTH = sida_pkg::DEF_TABLE_DEPTH,
    parameter int ID_WIDTH    = sida_pkg::DEF_ID_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_empty,
    output logic                             o_q_pop,
    input  sida_pkg::t_kind                  i_kind,
    input  logic [ID_WIDTH-1:0]              i_ident,
    output logic                             o_empty,
    input  logic                             i_pop,
    output logic [1:0]                       o_status,
    output logic [ID_WIDTH-1:0]              o_free_ident,
    output logic                             o_no_free,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] o_occupied_count
);

    import sida_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_W = $bits(t_status) + ID_WIDTH + 1 + CNT_W;

    t_state              r_state;
    t_state              n_state;
    t_kind               r_kind;
    logic [ID_WIDTH-1:0] r_ident;
    t_status             r_status;
    t_status             n_status;
    t_cell_ctl           w_ctl;
    logic                w_hit;
    logic                w_full;
    logic [CNT_W-1:0]    w_count;
    logic [ID_WIDTH-1:0] w_free;
    logic                w_no_free;
    logic                w_out_full;
    logic                w_out_push;
    logic [OUT_W-1:0]    w_out_head;

    sida_cells #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_cells (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ident      (r_ident),
        .i_ctl        (w_ctl),
        .o_hit        (w_hit),
        .o_full       (w_full),
        .o_count      (w_count),
        .o_free_ident (w_free),
        .o_no_free    (w_no_free)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = S_CMP;
                end
            end
            S_CMP:  n_state = S_HIT;
            S_HIT:  n_state = S_UPD;
            S_UPD:  n_state = S_GAP1;
            S_GAP1: n_state = S_GAP2;
            S_GAP2: n_state = S_PUSH;
            S_PUSH: begin
                if (!w_out_full) begin
                    n_state = i_q_empty ? S_IDLE : S_CMP;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop    = 1'b0;
        w_out_push = 1'b0;
        w_ctl      = '0;
        n_status   = ST_OK;
        case (r_state)
            S_IDLE: o_q_pop = !i_q_empty;
            S_UPD: begin
                case (r_kind)
                    K_INSERT: begin
                        if (w_hit) begin
                            n_status = ST_DUP;
                        end else if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            w_ctl.ins = 1'b1;
                        end
                    end
                    K_REMOVE: begin
                        if (w_hit) begin
                            w_ctl.del = 1'b1;
                        end else begin
                            n_status = ST_MISS;
                        end
                    end
                    default: n_status = ST_OK;
                endcase
            end
            S_PUSH: begin
                w_out_push = !w_out_full;
                o_q_pop    = !w_out_full && !i_q_empty;
            end
            default: o_q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_kind  <= i_kind;
            r_ident <= i_ident;
        end
        if (r_state == S_UPD) begin
            r_status <= n_status;
        end
    end

    sida_fifo #(
        .WIDTH (OUT_W)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  ({r_status, w_free, w_no_free, w_count}),
        .o_full  (w_out_full),
        .i_pop   (i_pop),
        .o_data  (w_out_head),
        .o_empty (o_empty)
    );

    assign o_status         = w_out_head[OUT_W-1 -: 2];
    assign o_free_ident     = w_out_head[CNT_W+1 +: ID_WIDTH];
    assign o_no_free        = w_out_head[CNT_W];
    assign o_occupied_count = w_out_head[CNT_W-1:0];

endmodule

`default_nettype wire

// ===== sv/sorted_id_set_allocator.sv =====
// Sorted identifier set allocator. The block holds up to TABLE_DEPTH distinct
// identifiers in ascending order and answers insert, remove and query beats,
// each of which yields exactly one result beat carrying a status, the lowest
// free identifier found above the first held entry, a no-free flag and the
// number of identifiers held. Input beats are taken while full is low and
// results are presented while empty is low, each side through its own
// two-entry queue, so either side may stall independently. The back end
// handles one item at a time and takes the next only after handing off the
// result (compare, hit reduction, shift update, two levels of the
// registered free-identifier search, then the hand-off into the result
// queue, which waits while that queue is full). Opcode 3 is treated as a
// query.
`default_nettype none

module sorted_id_set_allocator #(
    parameter int TABLE_DEPTH = sida_pkg::DEF_TABLE_DEPTH,
    parameter int ID_WIDTH    = sida_pkg::DEF_ID_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input side, queue-style.
    input  logic                             push,
    output logic                             full,
    input  logic [1:0]                       i_operation,
    input  logic [ID_WIDTH-1:0]              i_ident,
    // Result side, queue-style.
    output logic                             empty,
    input  logic                             pop,
    output logic [1:0]                       o_status,
    output logic [ID_WIDTH-1:0]              o_free_ident,
    output logic                             o_no_free,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] o_occupied_count
);

    import sida_pkg::*;

    // Handoff between the front queue and the back-end sequencer.
    logic                w_q_empty;
    logic                w_q_pop;
    t_kind               w_kind;
    logic [ID_WIDTH-1:0] w_ident;

    // The front end decodes the opcode into an operation kind and buffers
    // up to two beats, so new requests are accepted while the back end is busy.
    sida_front #(
        .ID_WIDTH (ID_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_operation (i_operation),
        .i_ident     (i_ident),
        .i_pop       (w_q_pop),
        .o_empty     (w_q_empty),
        .o_kind      (w_kind),
        .o_ident     (w_ident)
    );

    // The back end owns the cell array: every cell compares itself with the
    // broadcast identifier, an insert shifts the cells at and above the
    // insertion point up by one, and a remove shifts the cells above the
    // match down by one. The free identifier is found by a two-level
    // registered priority search over the ends of consecutive runs.
    sida_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (w_q_empty),
        .o_q_pop          (w_q_pop),
        .i_kind           (w_kind),
        .i_ident          (w_ident),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_status         (o_status),
        .o_free_ident     (o_free_ident),
        .o_no_free        (o_no_free),
        .o_occupied_count (o_occupied_count)
    );

endmodule

`default_nettype wire

// ===== sim/sorted_id_set_allocator_test.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the sorted identifier set allocator.
module sorted_id_set_allocator_test;
    import sida_pkg::*;

    localparam int DEPTH   = DEF_TABLE_DEPTH;
    localparam int ID_W    = DEF_ID_WIDTH;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    // The package only names insert and remove; code 2 is the query and code 3
    // is the spare code that the block must treat as a query.
    localparam logic [1:0] OPC_QUERY = 2'd2;
    localparam logic [1:0] OPC_SPARE = 2'd3;

    localparam logic [ID_W-1:0] ID_MAX = '1;

    // Stimulus length, the quiet tail without idling, and the run limit. The
    // limit assumes the block's own sequence plus the longest idle gap on both
    // sides for every beat and is then taken several times over.
    localparam int TOTAL_BEATS   = 1775;
    localparam int QUIET_BEATS   = 200;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 24;

    typedef struct packed {
        t_status              status;
        logic [ID_W-1:0]      free_ident;
        logic                 no_free;
        logic [COUNT_W-1:0]   occupied;
    } t_alloc_reply;

    // Scoreboard: keeps its own sorted copy of the occupied set, predicts the
    // result of every accepted request beat and checks result beats in order.
    class id_set_tracker;
        logic [ID_W-1:0] held_ids [DEPTH];
        int              held_count;
        t_alloc_reply    pending_replies [$];
        int              failures;

        function new();
            held_count = 0;
            failures   = 0;
        endfunction

        function void note_request(logic [1:0] op, logic [ID_W-1:0] ident);
            t_alloc_reply reply;
            int           slot;
            bit           hit;
            bit           gap;

            // Find the first held entry at or above the identifier.
            slot = held_count;
            hit  = 1'b0;
            for (int k = held_count - 1; k >= 0; k--) begin
                if (held_ids[k] >= ident) begin
                    slot = k;
                    hit  = (held_ids[k] == ident);
                end
            end

            reply.status = ST_OK;
            if (op == OPC_INSERT) begin
                // A duplicate wins over a full table.
                if (hit) begin
                    reply.status = ST_DUP;
                end else if (held_count >= DEPTH) begin
                    reply.status = ST_FULL;
                end else begin
                    for (int k = held_count; k > slot; k--)
                        held_ids[k] = held_ids[k-1];
                    held_ids[slot] = ident;
                    held_count++;
                end
            end else if (op == OPC_REMOVE) begin
                if (!hit) begin
                    reply.status = ST_MISS;
                end else begin
                    for (int k = slot; k + 1 < held_count; k++)
                        held_ids[k] = held_ids[k+1];
                    held_count--;
                end
            end

            // Free identifier: the first hole above the lowest entry, else one
            // past the top entry. A hole below the lowest entry is never offered.
            reply.no_free    = 1'b0;
            reply.free_ident = ID_W'(1);
            if (held_count > 0) begin
                gap = 1'b0;
                for (int k = 0; k + 1 < held_count; k++) begin
                    if (!gap && (held_ids[k] + ID_W'(1)) != held_ids[k+1]) begin
                        gap              = 1'b1;
                        reply.free_ident = held_ids[k] + ID_W'(1);
                    end
                end
                if (!gap) begin
                    if (held_ids[held_count-1] == ID_MAX) begin
                        reply.no_free    = 1'b1;
                        reply.free_ident = '0;
                    end else begin
                        reply.free_ident = held_ids[held_count-1] + ID_W'(1);
                    end
                end
            end
            reply.occupied = COUNT_W'(held_count);
            pending_replies.insert(pending_replies.size(), reply);
        endfunction

        function void check_reply(logic [1:0] status, logic [ID_W-1:0] free_ident,
                                  logic no_free, logic [COUNT_W-1:0] occupied);
            t_alloc_reply want;

            if (pending_replies.size() == 0) begin
                $error("result beat with no request outstanding (status %0d, free %0d)",
                       status, free_ident);
                failures++;
                return;
            end
            want = pending_replies.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                failures++;
            end
            if (free_ident !== want.free_ident) begin
                $error("free_ident: expected %0d, got %0d", want.free_ident, free_ident);
                failures++;
            end
            if (no_free !== want.no_free) begin
                $error("no_free: expected %0d, got %0d", want.no_free, no_free);
                failures++;
            end
            if (occupied !== want.occupied) begin
                $error("occupied_count: expected %0d, got %0d", want.occupied, occupied);
                failures++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [1:0]         i_operation;
    logic [ID_W-1:0]    i_ident;
    logic               empty;
    logic               pop;
    logic [1:0]         o_status;
    logic [ID_W-1:0]    o_free_ident;
    logic               o_no_free;
    logic [COUNT_W-1:0] o_occupied_count;

    id_set_tracker tracker = new();

    // Random idling on both sides is allowed only while this is set.
    bit idle_on = 1'b1;
    int beats_sent = 0;
    int cycle_count = 0;

    sorted_id_set_allocator u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_operation      (i_operation),
        .i_ident          (i_ident),
        .empty            (empty),
        .pop              (pop),
        .o_status         (o_status),
        .o_free_ident     (o_free_ident),
        .o_no_free        (o_no_free),
        .o_occupied_count (o_occupied_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Timeout guard: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** sorted_id_set_allocator: FAILED **");
            $finish;
        end
    end

    // Result side. Outputs are sampled at the rising edge, before the block's
    // own registers update, so every accepted beat is seen exactly once.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            tracker.check_reply(o_status, o_free_ident, o_no_free, o_occupied_count);
    end

    // The receiver either pops or stalls for a random burst.
    // Each falling edge carries exactly one assignment to pop.
    initial begin : result_pacer
        int stall_len;

        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_len = $urandom_range(1, 18);
                pop <= 1'b0;
                repeat (stall_len - 1) begin
                    @(negedge i_clk);
                    pop <= 1'b0;
                end
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Offers one request beat, possibly after an idle burst, and holds it until
    // the block accepts it. Push stays high into the next call, which either
    // presents the next beat or lowers push for a gap at the following fall.
    task automatic offer_request(input logic [1:0] op, input logic [ID_W-1:0] ident);
        int gap_len;

        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap_len = $urandom_range(1, 18);
            repeat (gap_len) begin
                @(negedge i_clk);
                push <= 1'b0;
            end
        end
        @(negedge i_clk);
        push        <= 1'b1;
        i_operation <= op;
        i_ident     <= ident;
        do
            @(posedge i_clk);
        while (full);
        tracker.note_request(op, ident);
        beats_sent++;
    endtask

    // Holds the sender back until every predicted result has come out.
    task automatic wait_for_replies();
        @(negedge i_clk);
        push <= 1'b0;
        while (tracker.pending_replies.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [ID_W-1:0] pick_held();
        return tracker.held_ids[$urandom_range(0, tracker.held_count - 1)];
    endfunction

    function automatic logic [1:0] pick_query();
        return ($urandom_range(0, 1) != 0) ? OPC_QUERY : OPC_SPARE;
    endfunction

    initial begin : stimulus
        int               mode;
        int               block_len;
        int               run_len;
        bit               run_down;
        logic [ID_W-1:0]  window_base;
        logic [ID_W-1:0]  run_base;

        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_operation = OPC_INSERT;
        i_ident     = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: empty set, both ends of the identifier range,
        // duplicates, misses, the spare code, a top entry with nothing free,
        // and a hole below the lowest entry that must not be offered.
        offer_request(OPC_QUERY,  16'h1234);
        offer_request(OPC_REMOVE, 16'h0005);
        offer_request(OPC_INSERT, 16'h0000);
        offer_request(OPC_INSERT, ID_MAX);
        offer_request(OPC_INSERT, 16'h0000);
        offer_request(OPC_SPARE,  ID_MAX);
        offer_request(OPC_INSERT, 16'h0001);
        offer_request(OPC_REMOVE, 16'h0000);
        offer_request(OPC_REMOVE, 16'h0001);
        offer_request(OPC_INSERT, ID_MAX - 16'd1);
        offer_request(OPC_INSERT, ID_MAX - 16'd3);
        offer_request(OPC_REMOVE, ID_MAX);
        offer_request(OPC_REMOVE, ID_MAX - 16'd3);
        offer_request(OPC_REMOVE, ID_MAX - 16'd1);
        offer_request(OPC_INSERT, 16'h8000);
        offer_request(OPC_INSERT, 16'h7FFF);
        offer_request(OPC_INSERT, 16'h8002);
        offer_request(OPC_QUERY,  16'h0000);
        offer_request(OPC_REMOVE, 16'h8000);
        offer_request(OPC_REMOVE, 16'h7FFF);
        offer_request(OPC_REMOVE, 16'h7FFF);
        offer_request(OPC_REMOVE, 16'h8002);
        wait_for_replies();

        // Random part, in blocks that each favor one kind of traffic.
        while (beats_sent < TOTAL_BEATS) begin
            idle_on   = (beats_sent < TOTAL_BEATS - QUIET_BEATS) && ($urandom_range(0, 3) != 0);
            mode      = $urandom_range(0, 5);
            block_len = $urandom_range(30, 80);
            case (mode)
                0, 1: begin
                    // Dense window: inserts outnumber removes, so the table fills
                    // up, duplicates and holes are common, and full is reached.
                    case ($urandom_range(0, 2))
                        0:       window_base = '0;
                        1:       window_base = ID_MAX - ID_W'(80);
                        default: window_base = ID_W'($urandom);
                    endcase
                    repeat (block_len) begin
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3, 4, 5:
                                offer_request(OPC_INSERT, window_base + ID_W'($urandom_range(0, 95)));
                            6, 7:
                                offer_request(OPC_REMOVE, (tracker.held_count > 0)
                                              ? pick_held()
                                              : window_base + ID_W'($urandom_range(0, 95)));
                            8:
                                offer_request(OPC_REMOVE, window_base + ID_W'($urandom_range(0, 95)));
                            default:
                                offer_request(pick_query(), ID_W'($urandom));
                        endcase
                    end
                end
                2: begin
                    // Drain: mostly removes of held identifiers.
                    repeat (block_len) begin
                        if (tracker.held_count > 0 && $urandom_range(0, 9) < 8)
                            offer_request(OPC_REMOVE, pick_held());
                        else if ($urandom_range(0, 1) != 0)
                            offer_request(OPC_REMOVE, ID_W'($urandom));
                        else
                            offer_request(pick_query(), ID_W'($urandom));
                    end
                end
                3, 4: begin
                    // Contiguous run on an emptied set. A run ending at the top
                    // identifier leaves nothing free; runs longer than the table
                    // hit the full case, and a final duplicate checks that a
                    // duplicate is reported ahead of fullness.
                    while (tracker.held_count > 0)
                        offer_request(OPC_REMOVE, pick_held());
                    run_len = $urandom_range(1, 70);
                    case ($urandom_range(0, 2))
                        0: begin
                            run_base = ID_MAX;
                            run_down = 1'b1;
                        end
                        1: begin
                            run_base = '0;
                            run_down = 1'b0;
                        end
                        default: begin
                            run_base = ID_W'($urandom);
                            run_down = ($urandom_range(0, 1) != 0);
                        end
                    endcase
                    for (int k = 0; k < run_len; k++)
                        offer_request(OPC_INSERT, run_down ? run_base - ID_W'(k)
                                                           : run_base + ID_W'(k));
                    offer_request(OPC_INSERT, pick_held());
                    offer_request(pick_query(), ID_W'($urandom));
                    if ($urandom_range(0, 2) == 0)
                        wait_for_replies();
                end
                default: begin
                    // Noise: any code, any identifier.
                    repeat (block_len)
                        offer_request(2'($urandom_range(0, 3)), ID_W'($urandom));
                end
            endcase
        end

        // Wind down: no more beats, collect what is still in flight, then give
        // the block time to show any result beat that nobody asked for.
        idle_on = 1'b0;
        wait_for_replies();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.failures == 0 && tracker.pending_replies.size() == 0) begin
            $display("** sorted_id_set_allocator: PASSED **");
        end else begin
            $display("** sorted_id_set_allocator: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/sida_pkg.sv
sv/sida_fifo.sv
sv/sida_front.sv
sv/sida_cells.sv
sv/sida_back.sv
sv/sorted_id_set_allocator.sv
sim/sorted_id_set_allocator_test.sv
